### hdl/shabsh_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// Used by the message schedule, the compression core and the top level.
// No dependencies.
`default_nettype none

package shabsh_pkg;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } t_state;

    // Controls for the message schedule window.
    typedef struct packed {
        logic load_byte;
        logic step;
    } t_sched_ctl;

    // Controls for the compression core.
    typedef struct packed {
        logic init;
        logic start;
        logic round;
        logic fold;
        logic shift;
    } t_core_ctl;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] BYTE_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST = 3'd7;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    // Initial hash value, one word per index.
    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        unique case (idx)
            3'd0: init_hash = 32'h6a09e667;
            3'd1: init_hash = 32'hbb67ae85;
            3'd2: init_hash = 32'h3c6ef372;
            3'd3: init_hash = 32'ha54ff53a;
            3'd4: init_hash = 32'h510e527f;
            3'd5: init_hash = 32'h9b05688c;
            3'd6: init_hash = 32'h1f83d9ab;
            3'd7: init_hash = 32'h5be0cd19;
            default: init_hash = 32'h0;
        endcase
    endfunction

    // Round constants.
    function automatic logic [31:0] round_const(input logic [5:0] idx);
        unique case (idx)
            6'd0:  round_const = 32'h428a2f98;
            6'd1:  round_const = 32'h71374491;
            6'd2:  round_const = 32'hb5c0fbcf;
            6'd3:  round_const = 32'he9b5dba5;
            6'd4:  round_const = 32'h3956c25b;
            6'd5:  round_const = 32'h59f111f1;
            6'd6:  round_const = 32'h923f82a4;
            6'd7:  round_const = 32'hab1c5ed5;
            6'd8:  round_const = 32'hd807aa98;
            6'd9:  round_const = 32'h12835b01;
            6'd10: round_const = 32'h243185be;
            6'd11: round_const = 32'h550c7dc3;
            6'd12: round_const = 32'h72be5d74;
            6'd13: round_const = 32'h80deb1fe;
            6'd14: round_const = 32'h9bdc06a7;
            6'd15: round_const = 32'hc19bf174;
            6'd16: round_const = 32'he49b69c1;
            6'd17: round_const = 32'hefbe4786;
            6'd18: round_const = 32'h0fc19dc6;
            6'd19: round_const = 32'h240ca1cc;
            6'd20: round_const = 32'h2de92c6f;
            6'd21: round_const = 32'h4a7484aa;
            6'd22: round_const = 32'h5cb0a9dc;
            6'd23: round_const = 32'h76f988da;
            6'd24: round_const = 32'h983e5152;
            6'd25: round_const = 32'ha831c66d;
            6'd26: round_const = 32'hb00327c8;
            6'd27: round_const = 32'hbf597fc7;
            6'd28: round_const = 32'hc6e00bf3;
            6'd29: round_const = 32'hd5a79147;
            6'd30: round_const = 32'h06ca6351;
            6'd31: round_const = 32'h14292967;
            6'd32: round_const = 32'h27b70a85;
            6'd33: round_const = 32'h2e1b2138;
            6'd34: round_const = 32'h4d2c6dfc;
            6'd35: round_const = 32'h53380d13;
            6'd36: round_const = 32'h650a7354;
            6'd37: round_const = 32'h766a0abb;
            6'd38: round_const = 32'h81c2c92e;
            6'd39: round_const = 32'h92722c85;
            6'd40: round_const = 32'ha2bfe8a1;
            6'd41: round_const = 32'ha81a664b;
            6'd42: round_const = 32'hc24b8b70;
            6'd43: round_const = 32'hc76c51a3;
            6'd44: round_const = 32'hd192e819;
            6'd45: round_const = 32'hd6990624;
            6'd46: round_const = 32'hf40e3585;
            6'd47: round_const = 32'h106aa070;
            6'd48: round_const = 32'h19a4c116;
            6'd49: round_const = 32'h1e376c08;
            6'd50: round_const = 32'h2748774c;
            6'd51: round_const = 32'h34b0bcb5;
            6'd52: round_const = 32'h391c0cb3;
            6'd53: round_const = 32'h4ed8aa4a;
            6'd54: round_const = 32'h5b9cca4f;
            6'd55: round_const = 32'h682e6ff3;
            6'd56: round_const = 32'h748f82ee;
            6'd57: round_const = 32'h78a5636f;
            6'd58: round_const = 32'h84c87814;
            6'd59: round_const = 32'h8cc70208;
            6'd60: round_const = 32'h90befffa;
            6'd61: round_const = 32'ha4506ceb;
            6'd62: round_const = 32'hbef9a3f7;
            6'd63: round_const = 32'hc67178f2;
            default: round_const = 32'h0;
        endcase
    endfunction

endpackage

`default_nettype wire

### hdl/shabsh_sched.sv
// Message schedule: a sixteen-word window that doubles as the block buffer.
// Depends on shabsh_pkg.
`default_nettype none

module shabsh_sched (
    input  wire logic                    i_clk,
    input  wire shabsh_pkg::t_sched_ctl  i_ctl,
    input  wire logic [7:0]              i_byte,
    output logic [31:0]                  o_w
);

    logic [31:0] r_w [16];
    logic [31:0] w_next;

    // Next schedule word from the window taps.
    assign w_next = shabsh_pkg::ssig1(r_w[14]) + r_w[9] + shabsh_pkg::ssig0(r_w[1]) + r_w[0];

    // Bytes enter at the low end of the last word; rounds shift whole words.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_byte) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], i_byte};
        end else if (i_ctl.step) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_next;
        end
    end

    assign o_w = r_w[0];

endmodule

`default_nettype wire

### hdl/shabsh_core.sv
// Compression core: chaining value, working variables and the shared round unit.
// Depends on shabsh_pkg.
`default_nettype none

module shabsh_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire shabsh_pkg::t_core_ctl  i_ctl,
    input  wire logic [5:0]             i_round,
    input  wire logic [31:0]            i_w,
    output logic [31:0]                 o_h0
);

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // One round of the compression function.
    always_comb begin
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + shabsh_pkg::bsig1(r_v[4]) + ch + shabsh_pkg::round_const(i_round) + i_w;
        t2  = shabsh_pkg::bsig0(r_v[0]) + maj;
    end

    // Chaining value: initial value, fold after a block, shift out as digest.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= shabsh_pkg::init_hash(3'(i));
            end
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end else if (i_ctl.shift) begin
            for (int i = 0; i < 7; i++) begin
                r_h[i] <= r_h[i+1];
            end
        end
    end

    // Working variables.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_h0 = r_h[0];

endmodule

`default_nettype wire

### hdl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream. Each input word carries one message byte (tuser low) or a
// finish request (tuser high). The byte that completes a 64-byte block starts 64 rounds
// on a single round unit, one round per cycle, then folds the result into the chaining
// value, and the input is held off until the fold is done. A finish shifts the padding
// and the 64-bit length into the block one byte per cycle (64 minus the pending byte
// count, or 64 more when 56 or more bytes are pending), runs one or two compressions,
// then offers the eight digest words, first word first, with tlast on the eighth. The
// input is not ready while a block is compressed, padded or the digest is being
// delivered; afterwards the block starts a fresh message. Depends on shabsh_pkg,
// shabsh_sched and shabsh_core.
`default_nettype none

module sha256_byte_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] kind
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic             o_m_axis_tlast    // last_word
);

    shabsh_pkg::t_state     r_state, n_state;
    logic [5:0]             r_fill, n_fill;
    logic [54:0]            r_blocks, n_blocks;
    logic [63:0]            r_total, n_total;
    logic                   r_first, n_first;
    logic                   r_lenblk, n_lenblk;
    logic                   r_padding, n_padding;
    logic [5:0]             r_rnd, n_rnd;
    logic [2:0]             r_idx, n_idx;

    shabsh_pkg::t_sched_ctl sched_ctl;
    shabsh_pkg::t_core_ctl  core_ctl;
    logic [7:0]             byte_in;
    logic [31:0]            w_cur;
    logic [31:0]            h0;

    shabsh_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .i_byte (byte_in),
        .o_w    (w_cur)
    );

    shabsh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_round (r_rnd),
        .i_w     (w_cur),
        .o_h0    (h0)
    );

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= shabsh_pkg::ST_IDLE;
            r_fill    <= '0;
            r_blocks  <= '0;
            r_first   <= 1'b0;
            r_lenblk  <= 1'b0;
            r_padding <= 1'b0;
            r_rnd     <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_blocks  <= n_blocks;
            r_first   <= n_first;
            r_lenblk  <= n_lenblk;
            r_padding <= n_padding;
            r_rnd     <= n_rnd;
            r_idx     <= n_idx;
        end
    end

    // Length field shift register.
    always_ff @(posedge i_clk) begin
        r_total <= n_total;
    end

    // Sequencer: next state and unit controls.
    always_comb begin
        n_state         = r_state;
        n_fill          = r_fill;
        n_blocks        = r_blocks;
        n_total         = r_total;
        n_first         = r_first;
        n_lenblk        = r_lenblk;
        n_padding       = r_padding;
        n_rnd           = r_rnd;
        n_idx           = r_idx;
        sched_ctl       = '0;
        core_ctl        = '0;
        byte_in         = i_s_axis_tdata;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;

        unique case (r_state)
            shabsh_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (!i_s_axis_tuser) begin
                        sched_ctl.load_byte = 1'b1;
                        n_fill = r_fill + 6'd1;
                        if (r_fill == shabsh_pkg::BYTE_LAST) begin
                            core_ctl.start = 1'b1;
                            n_rnd   = '0;
                            n_state = shabsh_pkg::ST_COMP;
                        end
                    end else begin
                        // Bit count of the message so far.
                        n_total   = {r_blocks, r_fill, 3'b000};
                        n_padding = 1'b1;
                        n_first   = 1'b1;
                        n_lenblk  = 1'b0;
                        n_state   = shabsh_pkg::ST_PAD;
                    end
                end
            end

            shabsh_pkg::ST_PAD: begin
                // Pad marker, then zeros, then the length in the final block.
                if (r_first) begin
                    byte_in  = shabsh_pkg::PAD_BYTE;
                    n_first  = 1'b0;
                    n_lenblk = (r_fill < shabsh_pkg::LEN_START);
                end else if (r_lenblk && (r_fill >= shabsh_pkg::LEN_START)) begin
                    byte_in = r_total[63:56];
                    n_total = {r_total[55:0], 8'h00};
                end else begin
                    byte_in = 8'h00;
                end
                sched_ctl.load_byte = 1'b1;
                n_fill = r_fill + 6'd1;
                if (r_fill == shabsh_pkg::BYTE_LAST) begin
                    core_ctl.start = 1'b1;
                    n_rnd   = '0;
                    n_state = shabsh_pkg::ST_COMP;
                end
            end

            shabsh_pkg::ST_COMP: begin
                core_ctl.round = 1'b1;
                sched_ctl.step = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == shabsh_pkg::ROUND_LAST) begin
                    n_state = shabsh_pkg::ST_FOLD;
                end
            end

            shabsh_pkg::ST_FOLD: begin
                core_ctl.fold = 1'b1;
                if (!r_padding) begin
                    n_blocks = r_blocks + 55'd1;
                    n_state  = shabsh_pkg::ST_IDLE;
                end else if (r_lenblk) begin
                    n_idx   = '0;
                    n_state = shabsh_pkg::ST_OUT;
                end else begin
                    // Pad marker spilled past the length field: one more block.
                    n_lenblk = 1'b1;
                    n_state  = shabsh_pkg::ST_PAD;
                end
            end

            shabsh_pkg::ST_OUT: begin
                o_m_axis_tvalid = 1'b1;
                if (i_m_axis_tready) begin
                    core_ctl.shift = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == shabsh_pkg::WORD_LAST) begin
                        // Digest delivered: start a new message.
                        core_ctl.init = 1'b1;
                        n_fill    = '0;
                        n_blocks  = '0;
                        n_padding = 1'b0;
                        n_lenblk  = 1'b0;
                        n_state   = shabsh_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = shabsh_pkg::ST_IDLE;
            end
        endcase
    end

    // Digest word output.
    assign o_m_axis_tdata = {5'b00000, r_idx, h0};
    assign o_m_axis_tlast = (r_idx == shabsh_pkg::WORD_LAST);

endmodule

`default_nettype wire
